// ===== src/plp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg
// Shared constants, types and arithmetic helpers for the label point block.
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int MAX_VERTICES  = 4096;
    localparam int MAX_CROSSINGS = 128;
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int VCNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VADDR_W       = $clog2(MAX_VERTICES);
    localparam int XCNT_W        = $clog2(MAX_CROSSINGS + 1);
    localparam int XADDR_W       = $clog2(MAX_CROSSINGS);

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_AREA  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [DIFF_W-1:0] adx;
        logic [DIFF_W-1:0] ey;
        logic [DIFF_W-1:0] dy;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic               vert;
        logic               neg;
        logic [COORD_W-1:0] x0;
        div_req_t           op;
    } cross_t;

    // (a + b) / 2, truncated toward zero
    function automatic logic signed [COORD_W-1:0] half_sum(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        s = s + {{(DIFF_W-1){1'b0}}, s[DIFF_W-1]};
        return s[DIFF_W-1:1];
    endfunction

    // d / 2 truncated toward zero, d is a wide difference
    function automatic logic signed [COORD_W-1:0] half_of(
        input logic signed [DIFF_W-1:0] d
    );
        logic signed [DIFF_W-1:0] s;
        s = d + {{(DIFF_W-1){1'b0}}, d[DIFF_W-1]};
        return s[DIFF_W-1:1];
    endfunction

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[DIFF_W-1] ? -d : d;
    endfunction

endpackage

// ===== src/plp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plp_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/plp_xdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_xdiv
// Edge interpolation unit: quot = (adx * ey) / dy, one bit of adx per cycle.
// Needs ey <= dy; the remainder then stays below dy.
// ----------------------------------------------------------------------------
module plp_xdiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  plp_pkg::div_req_t         req,
    output plp_pkg::div_stat_t        stat,
    output logic [plp_pkg::DIFF_W-1:0] quot
);
    import plp_pkg::*;

    localparam int BIT_W = $clog2(DIFF_W);
    localparam int T_W   = DIFF_W + 2;

    div_req_t          op_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [DIFF_W-1:0] q_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [T_W-1:0]    t;
    logic [T_W-1:0]    dy1;
    logic [T_W-1:0]    dy2;
    logic [DIFF_W-1:0] rem_next;
    logic [DIFF_W-1:0] q_next;
    logic [T_W-1:0]    t_red;
    logic [1:0]        inc;

    always_comb begin
        dy1 = {2'b00, op_reg.dy};
        dy2 = {1'b0, op_reg.dy, 1'b0};
        t   = {1'b0, rem_reg, 1'b0}
            + (op_reg.adx[bit_reg] ? {2'b00, op_reg.ey} : '0);
        if (t >= dy2) begin
            t_red = t - dy2;
            inc   = 2'd2;
        end else if (t >= dy1) begin
            t_red = t - dy1;
            inc   = 2'd1;
        end else begin
            t_red = t;
            inc   = 2'd0;
        end
        rem_next = t_red[DIFF_W-1:0];
        q_next   = {q_reg[DIFF_W-2:0], 1'b0} + {{(DIFF_W-2){1'b0}}, inc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end else if (busy_reg && bit_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= req;
            bit_reg <= BIT_W'(DIFF_W - 1);
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            bit_reg <= bit_reg - 1'b1;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

// ===== src/polygon_label_point_top.sv =====
`timescale 1ns / 1ps
// Sequence: a point or line result passes through ST_LABEL and ST_DONE after its last
// vertex. An area walks the ring over the vertex RAM (one read a cycle), then reads each
// crossing (ST_CROSS_RD, ST_CROSS_WAIT), runs the bit-serial interpolation divider
// (ST_DIV) for each edge crossing, then passes through ST_FINAL and ST_DONE.
// Throughput: one vertex per cycle while loading. Reset is synchronous, active low,
// and clears control state only; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// polygon_label_point_top
// Label point placement for point, line and area features.
// ----------------------------------------------------------------------------
module polygon_label_point_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_feature_kind,
    input  logic signed [plp_pkg::COORD_W-1:0] s_vertex_x,
    input  logic signed [plp_pkg::COORD_W-1:0] s_vertex_y,
    input  logic                        s_last_vertex,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_label_kind,
    output logic signed [plp_pkg::COORD_W-1:0] m_label_x,
    output logic signed [plp_pkg::COORD_W-1:0] m_label_y,
    output logic                        m_open_area_error
);
    import plp_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD       = 8'b0000_0001,
        ST_LABEL      = 8'b0000_0010,
        ST_WALK       = 8'b0000_0100,
        ST_CROSS_RD   = 8'b0000_1000,
        ST_CROSS_WAIT = 8'b0001_0000,
        ST_DIV        = 8'b0010_0000,
        ST_FINAL      = 8'b0100_0000,
        ST_DONE       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [VCNT_W-1:0]         vcnt_reg, np_reg;
    logic signed [COORD_W-1:0] north_reg, south_reg, east_reg, west_reg;
    logic signed [COORD_W-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    kind_t                     kind_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;

    logic [VCNT_W-1:0]         k_reg, rk_reg;
    logic                      rv_reg;
    logic signed [COORD_W-1:0] prev_y_reg, cur_y_reg, cur_x_reg;
    logic [XCNT_W-1:0]         xn_reg, z_reg;
    logic                      over_reg;

    logic signed [COORD_W-1:0] e1_reg, e2_reg, w1_reg, w2_reg;
    logic                      e1v_reg, e2v_reg, w1v_reg, w2v_reg;
    logic [XCNT_W-1:0]         ecnt_reg, wcnt_reg;

    logic signed [COORD_W-1:0] res_x_reg, res_y_reg;
    logic                      res_err_reg;

    logic                      m_valid_reg;
    logic [1:0]                m_kind_reg;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg;
    logic                      m_err_reg;

    // ---------------- ring storage ----------------
    logic                 accept;
    logic                 ring_we, ring_re;
    logic [VADDR_W-1:0]   ring_raddr;
    logic [2*COORD_W-1:0] ring_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;

    assign accept  = s_valid && s_ready;
    assign ring_we = accept && (vcnt_reg < VCNT_W'(MAX_VERTICES));

    plp_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_VERTICES)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (vcnt_reg[VADDR_W-1:0]),
        .wdata ({s_vertex_y, s_vertex_x}),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign rd_x = ring_rdata[COORD_W-1:0];
    assign rd_y = ring_rdata[2*COORD_W-1:COORD_W];

    // walk order: vertex N-2 first (predecessor of vertex 0), then 0 .. N-1
    logic [VCNT_W-1:0] walk_addr;
    always_comb begin
        walk_addr  = (k_reg == '0) ? (np_reg - VCNT_W'(2)) : (k_reg - VCNT_W'(1));
        ring_raddr = walk_addr[VADDR_W-1:0];
        ring_re    = (state_reg == ST_WALK) && (k_reg <= np_reg);
    end

    // ---------------- crossing detection ----------------
    logic   edge_hit, vert_hit, hit, room, walk_end;
    cross_t cr_w;
    logic [XCNT_W-1:0] xn_after;
    logic   over_after;

    always_comb begin
        edge_hit = (cur_y_reg > cy_reg && rd_y < cy_reg)
                || (cur_y_reg < cy_reg && rd_y > cy_reg);
        vert_hit = !edge_hit && (cur_y_reg == cy_reg)
                && ((rd_y > cy_reg && prev_y_reg < cy_reg)
                 || (rd_y < cy_reg && prev_y_reg > cy_reg));
        hit  = rv_reg && (rk_reg >= VCNT_W'(2)) && (edge_hit || vert_hit);
        room = xn_reg < XCNT_W'(MAX_CROSSINGS);
        cr_w.vert   = vert_hit;
        cr_w.neg    = rd_x < cur_x_reg;
        cr_w.x0     = cur_x_reg;
        cr_w.op.adx = abs_diff(rd_x, cur_x_reg);
        cr_w.op.dy  = abs_diff(cur_y_reg, rd_y);
        cr_w.op.ey  = abs_diff(cur_y_reg, cy_reg);
        xn_after    = xn_reg + ((hit && room) ? XCNT_W'(1) : XCNT_W'(0));
        over_after  = over_reg || (hit && !room);
        walk_end    = rv_reg && (rk_reg == np_reg);
    end

    logic [$bits(cross_t)-1:0] cr_rdata;
    cross_t cr_r;

    plp_ram #(.WIDTH($bits(cross_t)), .DEPTH(MAX_CROSSINGS)) u_cross (
        .aclk  (aclk),
        .we    (hit && room),
        .waddr (xn_reg[XADDR_W-1:0]),
        .wdata (cr_w),
        .re    (state_reg == ST_CROSS_RD),
        .raddr (z_reg[XADDR_W-1:0]),
        .rdata (cr_rdata)
    );

    assign cr_r = cross_t'(cr_rdata);

    // ---------------- interpolation ----------------
    logic              div_start;
    div_stat_t         div_stat;
    logic [DIFF_W-1:0] div_quot;

    assign div_start = (state_reg == ST_CROSS_WAIT) && !cr_r.vert;

    plp_xdiv u_xdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (cr_r.op),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    logic signed [COORD_W-1:0] xi;
    logic                      cls_en;
    logic                      cross_last;

    always_comb begin
        if (cr_r.vert) begin
            xi = cr_r.x0;
        end else if (cr_r.neg) begin
            xi = cr_r.x0 - div_quot[COORD_W-1:0];
        end else begin
            xi = cr_r.x0 + div_quot[COORD_W-1:0];
        end
        cls_en = ((state_reg == ST_CROSS_WAIT) && cr_r.vert)
              || ((state_reg == ST_DIV) && div_stat.done);
        cross_last = (z_reg + XCNT_W'(1)) == xn_reg;
    end

    // ---------------- bounding box centre and simple labels ----------------
    logic signed [COORD_W-1:0] bb_cx, bb_cy, line_px, line_py, fin_a, fin_b;
    logic                      fin_move;

    always_comb begin
        bb_cx = half_sum(west_reg, east_reg);
        bb_cy = half_sum(north_reg, south_reg);
        if (vcnt_reg >= VCNT_W'(2)) begin
            line_px = fx_reg + half_of({sx_reg[COORD_W-1], sx_reg} - {fx_reg[COORD_W-1], fx_reg});
            line_py = fy_reg + half_of({sy_reg[COORD_W-1], sy_reg} - {fy_reg[COORD_W-1], fy_reg});
        end else begin
            line_px = fx_reg;
            line_py = fy_reg;
        end
        fin_a    = e1_reg;
        fin_b    = e2_reg;
        fin_move = 1'b0;
        if (ecnt_reg != '0 && !ecnt_reg[0]) begin
            fin_move = e2v_reg;
        end else if (wcnt_reg != '0 && !wcnt_reg[0]) begin
            fin_a    = w1_reg;
            fin_b    = w2_reg;
            fin_move = w2v_reg;
        end
        if (ecnt_reg[0] && wcnt_reg[0]) begin
            fin_a    = e1_reg;
            fin_b    = w1_reg;
            fin_move = 1'b1;
        end
    end

    // ---------------- control ----------------
    assign s_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && s_last_vertex) begin
                    state_next = ST_LABEL;
                end
            end
            ST_LABEL: begin
                unique case (kind_reg) inside
                    KIND_POINT, KIND_LINE: state_next = ST_DONE;
                    KIND_AREA: state_next = (vcnt_reg < VCNT_W'(2)) ? ST_DONE : ST_WALK;
                    default:   state_next = ST_LOAD;
                endcase
            end
            ST_WALK: begin
                if (walk_end) begin
                    if (over_after || xn_after == '0 || xn_after[0]) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CROSS_RD;
                    end
                end
            end
            ST_CROSS_RD:   state_next = ST_CROSS_WAIT;
            ST_CROSS_WAIT: begin
                if (!cr_r.vert) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = cross_last ? ST_FINAL : ST_CROSS_RD;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = cross_last ? ST_FINAL : ST_CROSS_RD;
                end
            end
            ST_FINAL: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            vcnt_reg    <= '0;
            north_reg   <= '0;
            south_reg   <= '0;
            east_reg    <= '0;
            west_reg    <= '0;
            rv_reg      <= 1'b0;
            k_reg       <= '0;
            xn_reg      <= '0;
            over_reg    <= 1'b0;
            z_reg       <= '0;
            ecnt_reg    <= '0;
            wcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (ring_we) begin
                vcnt_reg <= vcnt_reg + VCNT_W'(1);
                if (vcnt_reg == '0) begin
                    north_reg <= s_vertex_y;
                    south_reg <= s_vertex_y;
                    east_reg  <= s_vertex_x;
                    west_reg  <= s_vertex_x;
                end else begin
                    if (s_vertex_y > north_reg) north_reg <= s_vertex_y;
                    if (s_vertex_y < south_reg) south_reg <= s_vertex_y;
                    if (s_vertex_x > east_reg)  east_reg  <= s_vertex_x;
                    if (s_vertex_x < west_reg)  west_reg  <= s_vertex_x;
                end
            end

            if (state_reg == ST_LABEL) begin
                vcnt_reg <= '0;
                k_reg    <= '0;
                rv_reg   <= 1'b0;
                xn_reg   <= '0;
                over_reg <= 1'b0;
                z_reg    <= '0;
                ecnt_reg <= '0;
                wcnt_reg <= '0;
            end

            if (state_reg == ST_WALK) begin
                if (ring_re) begin
                    k_reg <= k_reg + VCNT_W'(1);
                end
                rv_reg   <= ring_re;
                xn_reg   <= xn_after;
                over_reg <= over_after;
            end

            if (cls_en) begin
                z_reg <= z_reg + XCNT_W'(1);
                if (xi > cx_reg) begin
                    ecnt_reg <= ecnt_reg + XCNT_W'(1);
                end else begin
                    wcnt_reg <= wcnt_reg + XCNT_W'(1);
                end
            end

            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_t'(s_feature_kind);
            if (ring_we && vcnt_reg == '0) begin
                fx_reg <= s_vertex_x;
                fy_reg <= s_vertex_y;
            end
            if (ring_we && vcnt_reg == VCNT_W'(1)) begin
                sx_reg <= s_vertex_x;
                sy_reg <= s_vertex_y;
            end
        end

        if (state_reg == ST_LABEL) begin
            np_reg  <= vcnt_reg;
            cx_reg  <= bb_cx;
            cy_reg  <= bb_cy;
            e1v_reg <= 1'b0;
            e2v_reg <= 1'b0;
            w1v_reg <= 1'b0;
            w2v_reg <= 1'b0;
            if (kind_reg == KIND_POINT) begin
                res_x_reg   <= fx_reg;
                res_y_reg   <= fy_reg;
                res_err_reg <= 1'b0;
            end else if (kind_reg == KIND_LINE) begin
                res_x_reg   <= line_px;
                res_y_reg   <= line_py;
                res_err_reg <= 1'b0;
            end else begin
                res_y_reg   <= bb_cy;
                res_x_reg   <= bb_cx;
                res_err_reg <= 1'b1;
            end
        end

        // the first read returns vertex N-2, kept as predecessor of vertex 0
        if (state_reg == ST_WALK && rv_reg) begin
            if (rk_reg == '0) begin
                prev_y_reg <= rd_y;
            end else if (rk_reg != VCNT_W'(1)) begin
                prev_y_reg <= cur_y_reg;
            end
            if (rk_reg != '0) begin
                cur_y_reg <= rd_y;
                cur_x_reg <= rd_x;
            end
        end
        if (state_reg == ST_WALK) begin
            rk_reg <= k_reg;
        end

        if (cls_en) begin
            if (xi > cx_reg) begin
                if (!e1v_reg) begin
                    e1_reg  <= xi;
                    e1v_reg <= 1'b1;
                end else if (xi < e1_reg) begin
                    e2_reg  <= e1_reg;
                    e2v_reg <= 1'b1;
                    e1_reg  <= xi;
                end else if (!e2v_reg || xi < e2_reg) begin
                    e2_reg  <= xi;
                    e2v_reg <= 1'b1;
                end
            end else begin
                if (!w1v_reg) begin
                    w1_reg  <= xi;
                    w1v_reg <= 1'b1;
                end else if (xi > w1_reg) begin
                    w2_reg  <= w1_reg;
                    w2v_reg <= 1'b1;
                    w1_reg  <= xi;
                end else if (!w2v_reg || xi > w2_reg) begin
                    w2_reg  <= xi;
                    w2v_reg <= 1'b1;
                end
            end
        end

        if (state_reg == ST_FINAL) begin
            res_x_reg   <= fin_move ? half_sum(fin_a, fin_b) : cx_reg;
            res_y_reg   <= cy_reg;
            res_err_reg <= 1'b0;
        end

        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_kind_reg <= kind_reg;
            m_x_reg    <= res_x_reg;
            m_y_reg    <= res_y_reg;
            m_err_reg  <= res_err_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_label_kind      = m_kind_reg;
    assign m_label_x         = m_x_reg;
    assign m_label_y         = m_y_reg;
    assign m_open_area_error = m_err_reg;

`ifndef SYNTHESIS
    a_vcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count beyond ring depth");

    a_xn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        xn_reg <= XCNT_W'(MAX_CROSSINGS))
        else $error("crossing count beyond store depth");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("interpolation started while busy");

    a_side_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |-> ((ecnt_reg + wcnt_reg) == xn_reg))
        else $error("east and west counts do not cover all crossings");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid)
        else $error("result not presented");
`endif

endmodule
